### sv/gbs_pkg.sv
// Shared types and constants for the greedy box suppression block.
`timescale 1ns / 1ps
package gbs_pkg;

  localparam int COORD_W    = 16;
  localparam int ANCHOR_W   = 11;
  localparam int THR_W      = 9;
  localparam logic [THR_W-1:0] THR_RESET = 9'd115;
  localparam int PIPE_DEPTH = 4;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t ymin;
    coord_t xmin;
    coord_t ymax;
    coord_t xmax;
  } box_t;

  typedef struct packed {
    logic vld;
    logic hit;
  } iou_res_t;

endpackage

### sv/gbs_cell.sv
// One ring cell: holds a kept box, passes it to its neighbor or loads a new one.
`timescale 1ns / 1ps
module gbs_cell
  import gbs_pkg::*;
(
  input  logic clk,
  input  logic shift_en,
  input  logic load_en,
  input  box_t load_box,
  input  box_t next_box,
  output box_t box
);

  box_t box_r;
  box_t box_nxt;

  always_comb begin
    box_nxt = box_r;
    if (load_en) begin
      box_nxt = load_box;
    end else if (shift_en) begin
      box_nxt = next_box;
    end
  end

  always_ff @(posedge clk) begin
    box_r <= box_nxt;
  end

  assign box = box_r;

endmodule

### sv/gbs_iou.sv
// Pipelined overlap test of a candidate box against one stored box.
`timescale 1ns / 1ps
module gbs_iou
  import gbs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  box_t             cand,
  input  box_t             other,
  input  logic [THR_W-1:0] thr,
  output iou_res_t         res
);

  logic signed [16:0] iw_raw;
  logic signed [16:0] ih_raw;
  coord_t             min_xmax;
  coord_t             max_xmin;
  coord_t             min_ymax;
  coord_t             max_ymin;

  logic               v1_r, v2_r, v3_r, v4_r;
  logic [15:0]        iw1_r, ih1_r;
  logic signed [16:0] dxa1_r, dya1_r, dxb1_r, dyb1_r;
  logic [31:0]        inter2_r;
  logic signed [33:0] areaa2_r, areab2_r;
  logic signed [35:0] uni3_r;
  logic [31:0]        inter3_r;
  logic signed [45:0] prod4_r;
  logic [31:0]        inter4_r;
  logic               upos4_r;
  logic               thrz4_r;
  logic signed [45:0] inter_sh;

  always_comb begin
    min_xmax = (cand.xmax < other.xmax) ? cand.xmax : other.xmax;
    max_xmin = (cand.xmin > other.xmin) ? cand.xmin : other.xmin;
    min_ymax = (cand.ymax < other.ymax) ? cand.ymax : other.ymax;
    max_ymin = (cand.ymin > other.ymin) ? cand.ymin : other.ymin;
    iw_raw   = 17'(min_xmax) - 17'(max_xmin);
    ih_raw   = 17'(min_ymax) - 17'(max_ymin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    iw1_r    <= iw_raw[16] ? 16'd0 : iw_raw[15:0];
    ih1_r    <= ih_raw[16] ? 16'd0 : ih_raw[15:0];
    dxa1_r   <= 17'(cand.xmax) - 17'(cand.xmin);
    dya1_r   <= 17'(cand.ymax) - 17'(cand.ymin);
    dxb1_r   <= 17'(other.xmax) - 17'(other.xmin);
    dyb1_r   <= 17'(other.ymax) - 17'(other.ymin);
    inter2_r <= iw1_r * ih1_r;
    areaa2_r <= dxa1_r * dya1_r;
    areab2_r <= dxb1_r * dyb1_r;
    uni3_r   <= 36'(areaa2_r) + 36'(areab2_r) - $signed({4'b0, inter2_r});
    inter3_r <= inter2_r;
    prod4_r  <= $signed({1'b0, thr}) * uni3_r;
    inter4_r <= inter3_r;
    upos4_r  <= (uni3_r > 36'sd0);
    thrz4_r  <= (thr == '0);
  end

  assign inter_sh = $signed({6'b0, inter4_r, 8'b0});

  always_comb begin
    res.vld = v4_r;
    res.hit = upos4_r ? (inter_sh >= prod4_r) : thrz4_r;
  end

endmodule

### sv/greedy_box_suppression_top.sv
// Greedy box suppression: ring of kept-box cells rotating past one overlap unit.
//
//   port group | dir | handshake           | beat
//   in_        | in  | in_valid / in_stall  | one candidate box
//   out_       | out | out_valid / out_stall| one keep/suppress verdict
//   cfg_       | in  | cfg_valid / cfg_ready| overlap threshold (1/256 units)
//
// Each candidate is accepted, then the ring rotates every stored box past the
// overlap unit, the overlap pipeline drains, and the verdict is registered.
// The next candidate is taken once the verdict is registered; a stalled
// verdict holds the block only at the next verdict.
// Reset empties the store through the kept count alone; no clearing pass.
`timescale 1ns / 1ps
module greedy_box_suppression_top
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ANCHOR_W-1:0] in_anchor_index,
  input  coord_t              in_box_ymin,
  input  coord_t              in_box_xmin,
  input  coord_t              in_box_ymax,
  input  coord_t              in_box_xmax,
  input  logic                in_last_box,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ANCHOR_W-1:0] out_kept_index,
  output logic                out_keep,
  output logic                out_store_full,
  output logic                out_frame_end,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [THR_W-1:0]    cfg_data
);

  localparam int CNT_W  = $clog2(MAX_KEPT + 1);
  localparam int STEP_N = (MAX_KEPT > PIPE_DEPTH) ? MAX_KEPT : PIPE_DEPTH;
  localparam int STEP_W = $clog2(STEP_N);
  localparam int CMP_W  = (STEP_W > CNT_W) ? STEP_W : CNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                sup_r, sup_nxt;
  logic [THR_W-1:0]    thr_r;
  box_t                cand_r;
  logic [ANCHOR_W-1:0] anchor_r;
  logic                last_r;
  logic                out_valid_r;
  logic [ANCHOR_W-1:0] out_index_r;
  logic                out_keep_r;
  logic                out_full_r;
  logic                out_end_r;

  logic     in_fire;
  logic     fin_fire;
  logic     keep;
  logic     full;
  logic     store_en;
  logic     scan_vld;
  iou_res_t iou_res;
  box_t     cell_box [MAX_KEPT];

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign fin_fire  = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign keep      = !sup_r;
  assign full      = keep && (count_r == CNT_W'(MAX_KEPT));
  assign store_en  = fin_fire && keep && !full;
  assign scan_vld  = (state_r == ST_SCAN) && (CMP_W'(step_r) < CMP_W'(count_r));

  for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
    gbs_cell u_cell (
      .clk      (clk),
      .shift_en (state_r == ST_SCAN),
      .load_en  (store_en && (count_r == CNT_W'(i))),
      .load_box (cand_r),
      .next_box (cell_box[(i + 1) % MAX_KEPT]),
      .box      (cell_box[i])
    );
  end

  gbs_iou u_iou (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (scan_vld),
    .cand   (cand_r),
    .other  (cell_box[0]),
    .thr    (thr_r),
    .res    (iou_res)
  );

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    count_nxt = count_r;
    sup_nxt   = sup_r | (iou_res.vld & iou_res.hit);
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SCAN;
          step_nxt  = '0;
          sup_nxt   = 1'b0;
        end
      end
      ST_SCAN: begin
        if (step_r == STEP_W'(MAX_KEPT - 1)) begin
          state_nxt = ST_DRAIN;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (step_r == STEP_W'(PIPE_DEPTH - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FIN: begin
        if (fin_fire) begin
          state_nxt = ST_IDLE;
          if (last_r) begin
            count_nxt = '0;
          end else if (store_en) begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      sup_r       <= 1'b0;
      thr_r       <= THR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      count_r <= count_nxt;
      sup_r   <= sup_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cand_r   <= '{ymin: in_box_ymin, xmin: in_box_xmin,
                     ymax: in_box_ymax, xmax: in_box_xmax};
      anchor_r <= in_anchor_index;
      last_r   <= in_last_box;
    end
    if (fin_fire) begin
      out_index_r <= anchor_r;
      out_keep_r  <= keep;
      out_full_r  <= full;
      out_end_r   <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kept_index = out_index_r;
  assign out_keep       = out_keep_r;
  assign out_store_full = out_full_r;
  assign out_frame_end  = out_end_r;

endmodule

### tb/tb.sv
// Testbench for greedy_box_suppression_top: directed table, then random frames vs. a predictor.
`timescale 1ns / 1ps
module tb;
  import gbs_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int SEG_ITEMS = 250;
  localparam int MAX_PRINTED = 40;
  localparam int DIR_ROWS = 20;

  typedef struct {
    logic [ANCHOR_W-1:0] anchor;
    box_t                box;
    logic                last;
  } cand_t;

  typedef struct {
    logic [ANCHOR_W-1:0] index;
    logic                keep;
    logic                full;
    logic                frame_end;
  } verdict_t;

  typedef struct {
    cand_t            cand;
    logic [THR_W-1:0] thr;
    bit               typed;
    logic             keep;
    logic             full;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [ANCHOR_W-1:0] in_anchor_index = '0;
  coord_t              in_box_ymin = '0;
  coord_t              in_box_xmin = '0;
  coord_t              in_box_ymax = '0;
  coord_t              in_box_xmax = '0;
  logic                in_last_box = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [ANCHOR_W-1:0] out_kept_index;
  logic                out_keep;
  logic                out_store_full;
  logic                out_frame_end;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [THR_W-1:0]    cfg_data = '0;

  box_t             kept_store [STORE_DEPTH];
  int               kept_total = 0;
  logic [THR_W-1:0] cur_thr = THR_RESET;
  verdict_t         expected_verdicts [$];
  cand_t            frame_q [$];
  dir_row_t         dir_rows [DIR_ROWS];
  int               mismatch_count = 0;
  int               accepted_count = 0;
  int               cycle_count = 0;
  int               send_idle_pct = 23;
  int               recv_idle_pct = 65;
  bit               hold_off = 1'b0;

  greedy_box_suppression_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_anchor_index (in_anchor_index),
    .in_box_ymin     (in_box_ymin),
    .in_box_xmin     (in_box_xmin),
    .in_box_ymax     (in_box_ymax),
    .in_box_xmax     (in_box_xmax),
    .in_last_box     (in_last_box),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kept_index  (out_kept_index),
    .out_keep        (out_keep),
    .out_store_full  (out_store_full),
    .out_frame_end   (out_frame_end),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic bit boxes_collide(box_t a, box_t b, logic [THR_W-1:0] thr);
    longint ay0, ax0, ay1, ax1, by0, bx0, by1, bx1;
    longint w, h, inter, area_a, area_b, uni;
    ay0 = $signed(a.ymin);
    ax0 = $signed(a.xmin);
    ay1 = $signed(a.ymax);
    ax1 = $signed(a.xmax);
    by0 = $signed(b.ymin);
    bx0 = $signed(b.xmin);
    by1 = $signed(b.ymax);
    bx1 = $signed(b.xmax);
    w = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
    if (w < 0) w = 0;
    h = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
    if (h < 0) h = 0;
    inter = w * h;
    area_a = (ax1 - ax0) * (ay1 - ay0);
    area_b = (bx1 - bx0) * (by1 - by0);
    uni = area_a + area_b - inter;
    if (uni <= 0) return (thr == 0);
    return (inter * 256 >= longint'(thr) * uni);
  endfunction

  // advance the kept-box store by one candidate
  function automatic verdict_t judge_box(cand_t c);
    verdict_t v;
    int k;
    int n;
    n = kept_total;
    v.keep = 1'b1;
    v.full = 1'b0;
    for (k = 0; k < n && v.keep; k++) begin
      if (boxes_collide(c.box, kept_store[k], cur_thr)) v.keep = 1'b0;
    end
    if (v.keep) begin
      if (n < STORE_DEPTH) begin
        kept_store[n] = c.box;
        kept_total = n + 1;
      end else begin
        v.full = 1'b1;
      end
    end
    v.index = c.anchor;
    v.frame_end = c.last;
    if (c.last) kept_total = 0;
    return v;
  endfunction

  function automatic dir_row_t make_row(int anchor, int ymin, int xmin, int ymax, int xmax,
                                        bit last, int thr, bit typed, bit keep, bit full);
    dir_row_t r;
    r.cand.anchor = anchor[ANCHOR_W-1:0];
    r.cand.box.ymin = ymin[COORD_W-1:0];
    r.cand.box.xmin = xmin[COORD_W-1:0];
    r.cand.box.ymax = ymax[COORD_W-1:0];
    r.cand.box.xmax = xmax[COORD_W-1:0];
    r.cand.last = last;
    r.thr = thr[THR_W-1:0];
    r.typed = typed;
    r.keep = keep;
    r.full = full;
    return r;
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  function automatic void build_frame();
    cand_t c;
    int kind, n, k, nobj, o;
    int cy [3];
    int cx [3];
    int sy [3];
    int sx [3];
    int y0, x0;
    frame_q.delete();
    kind = $urandom_range(99);
    nobj = $urandom_range(1, 3);
    for (o = 0; o < 3; o++) begin
      cy[o] = int'($urandom_range(40000)) - 20000;
      cx[o] = int'($urandom_range(40000)) - 20000;
      sy[o] = $urandom_range(200, 6000);
      sx[o] = $urandom_range(200, 6000);
    end
    if (kind < 55) n = $urandom_range(1, 12);
    else if (kind < 65) n = STORE_DEPTH + $urandom_range(0, 6);
    else if (kind < 85) n = $urandom_range(1, 10);
    else n = $urandom_range(1, 8);
    for (k = 0; k < n; k++) begin
      c.anchor = ANCHOR_W'($urandom_range(2 ** ANCHOR_W - 1));
      c.last = (k == n - 1);
      if (kind < 55 || kind >= 85) begin
        o = $urandom_range(nobj - 1);
        y0 = cy[o] - sy[o] + jitter(sy[o] / 4);
        x0 = cx[o] - sx[o] + jitter(sx[o] / 4);
        c.box.ymin = y0[COORD_W-1:0];
        c.box.xmin = x0[COORD_W-1:0];
        y0 = cy[o] + sy[o] + jitter(sy[o] / 4);
        x0 = cx[o] + sx[o] + jitter(sx[o] / 4);
        c.box.ymax = y0[COORD_W-1:0];
        c.box.xmax = x0[COORD_W-1:0];
        if (kind >= 85) c.last = 1'b0;
      end else if (kind < 65) begin
        x0 = -32000 + k * 900;
        y0 = -int'($urandom_range(30000));
        c.box.xmin = x0[COORD_W-1:0];
        x0 = x0 + $urandom_range(1, 800);
        c.box.xmax = x0[COORD_W-1:0];
        c.box.ymin = y0[COORD_W-1:0];
        y0 = y0 + $urandom_range(1, 30000);
        c.box.ymax = y0[COORD_W-1:0];
      end else begin
        c.box = {$urandom, $urandom};
        if ($urandom_range(3) == 0) c.last = 1'($urandom_range(1));
      end
      frame_q.insert(frame_q.size(), c);
    end
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_PRINTED) $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_box(cand_t c, bit typed, bit keep, bit full);
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_anchor_index <= c.anchor;
    in_box_ymin <= c.box.ymin;
    in_box_xmin <= c.box.xmin;
    in_box_ymax <= c.box.ymax;
    in_box_xmax <= c.box.xmax;
    in_last_box <= c.last;
    do @(posedge clk); while (in_stall);
    v = judge_box(c);
    if (typed) begin
      v.keep = keep;
      v.full = full;
    end
    expected_verdicts.insert(expected_verdicts.size(), v);
    accepted_count++;
  endtask

  task automatic set_threshold(logic [THR_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cur_thr = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // hold off the receiver long enough to back the block up into its input
  initial begin
    wait (accepted_count >= 60);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    verdict_t ev;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("verdict for anchor %0d with nothing expected",
                                  out_kept_index));
      end else begin
        ev = expected_verdicts.pop_front();
        if (out_kept_index !== ev.index)
          report_mismatch($sformatf("kept_index %0d, expected %0d", out_kept_index, ev.index));
        if (out_keep !== ev.keep)
          report_mismatch($sformatf("anchor %0d keep %b, expected %b",
                                    ev.index, out_keep, ev.keep));
        if (out_store_full !== ev.full)
          report_mismatch($sformatf("anchor %0d store_full %b, expected %b",
                                    ev.index, out_store_full, ev.full));
        if (out_frame_end !== ev.frame_end)
          report_mismatch($sformatf("anchor %0d frame_end %b, expected %b",
                                    ev.index, out_frame_end, ev.frame_end));
      end
    end
  end

  initial begin
    dir_row_t r;
    logic [THR_W-1:0] seg_thr [6];
    int seg, seg_items, k;

    // anchor, ymin, xmin, ymax, xmax, last, thr, typed, keep, full
    dir_rows[0]  = make_row(0, 0, 0, 100, 100, 0, 115, 1, 1, 0);
    dir_rows[1]  = make_row(2047, 0, 0, 100, 100, 0, 115, 1, 0, 0);
    dir_rows[2]  = make_row(5, -32768, -32768, 32767, 32767, 0, 115, 0, 0, 0);
    dir_rows[3]  = make_row(6, 100, 100, 0, 0, 0, 115, 0, 0, 0);
    dir_rows[4]  = make_row(1024, 50, 50, 50, 90, 0, 115, 0, 0, 0);
    dir_rows[5]  = make_row(7, 0, 0, 100, 100, 1, 115, 1, 0, 0);
    dir_rows[6]  = make_row(8, 0, 0, 100, 100, 0, 115, 1, 1, 0);
    dir_rows[7]  = make_row(9, 0, 50, 100, 150, 0, 115, 0, 0, 0);
    dir_rows[8]  = make_row(1023, -32768, -32768, -32768, -32768, 0, 115, 0, 0, 0);
    dir_rows[9]  = make_row(1365, 32767, 32767, 32767, 32767, 1, 115, 0, 0, 0);
    dir_rows[10] = make_row(10, 0, 0, 10, 10, 0, 0, 1, 1, 0);
    dir_rows[11] = make_row(11, 1000, 1000, 1010, 1010, 0, 0, 1, 0, 0);
    dir_rows[12] = make_row(12, 20, 20, 0, 0, 1, 0, 1, 0, 0);
    dir_rows[13] = make_row(13, 0, 0, 100, 100, 0, 256, 1, 1, 0);
    dir_rows[14] = make_row(14, 0, 0, 100, 100, 0, 256, 1, 0, 0);
    dir_rows[15] = make_row(15, 0, 0, 100, 99, 0, 256, 0, 0, 0);
    dir_rows[16] = make_row(682, -5000, 3000, 7000, -2000, 1, 256, 0, 0, 0);
    dir_rows[17] = make_row(16, 0, 0, 100, 100, 0, 511, 1, 1, 0);
    dir_rows[18] = make_row(17, 0, 0, 100, 100, 0, 511, 0, 0, 0);
    dir_rows[19] = make_row(18, 100, 100, 0, 0, 1, 511, 0, 0, 0);

    seg_thr[0] = THR_RESET;
    seg_thr[1] = 9'd256;
    seg_thr[2] = THR_W'($urandom_range(1, 255));
    seg_thr[3] = '0;
    seg_thr[4] = '1;
    seg_thr[5] = THR_W'($urandom_range(2 ** THR_W - 1));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      if (r.thr != cur_thr) set_threshold(r.thr);
      send_box(r.cand, r.typed, r.keep, r.full);
    end

    for (seg = 0; seg < 6; seg++) begin
      set_threshold(seg_thr[seg]);
      if (seg < 2) begin
        send_idle_pct = 23;
        recv_idle_pct = 65;
      end else if (seg < 4) begin
        send_idle_pct = 65;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      seg_items = 0;
      while (seg_items < SEG_ITEMS) begin
        build_frame();
        for (k = 0; k < frame_q.size(); k++) send_box(frame_q[k], 1'b0, 1'b0, 1'b0);
        seg_items += frame_q.size();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
sv/gbs_pkg.sv
sv/gbs_cell.sv
sv/gbs_iou.sv
sv/greedy_box_suppression_top.sv
tb/tb.sv
